>>> rtl/quad_projective_weight_setup_unit_defines.svh
// Assertion macros shared by the checker files.
`ifndef QUAD_PROJECTIVE_WEIGHT_SETUP_UNIT_DEFINES_SVH
`define QUAD_PROJECTIVE_WEIGHT_SETUP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define QPWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qpws check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define QPWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qpws check failed");

`endif

>>> rtl/qpws_pkg.sv
// ----------------------------------------------------------------------------
// qpws_pkg
// Widths and types for the quad projective weight setup pipeline.
// ----------------------------------------------------------------------------
package qpws_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int WEIGHT_WIDTH = 24;
	localparam int FRAC_BITS    = 16;

	// corner differences, cross products, den minus numerator
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int DEN_W   = CROSS_W + 1;
	// distance magnitudes and distance sums
	localparam int MAG_W   = DEN_W;
	localparam int SUM_W   = MAG_W + 1;
	// divider remainder, holds both sum << FRAC_BITS and divisor << (WEIGHT_WIDTH-1)
	localparam int REM_W   = SUM_W + WEIGHT_WIDTH;

	localparam int LANES     = 4;
	localparam int FRONT_ST  = 6;
	localparam int NUM_ST    = FRONT_ST + WEIGHT_WIDTH;

	localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = '1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [WEIGHT_WIDTH-1:0] weight_t;

	// one divider lane: partial remainder, divisor, quotient so far, saturate
	typedef struct packed {
		logic [REM_W-1:0]        rem;
		logic [MAG_W-1:0]        dvs;
		logic [WEIGHT_WIDTH-1:0] quo;
		logic                    sat;
	} div_lane_t;

	typedef struct packed {
		logic                   degen;
		div_lane_t [LANES-1:0]  lane;
	} div_stage_t;

endpackage

>>> rtl/qpws_in_if.sv
// ----------------------------------------------------------------------------
// qpws_in_if
// Input channel: one quadrilateral, four corners, per beat.
// ----------------------------------------------------------------------------
interface qpws_in_if
	import qpws_pkg::*;
();
	logic   valid;
	logic   ready;
	coord_t corner1_x;
	coord_t corner1_y;
	coord_t corner2_x;
	coord_t corner2_y;
	coord_t corner3_x;
	coord_t corner3_y;
	coord_t corner4_x;
	coord_t corner4_y;

	modport source (output valid, corner1_x, corner1_y, corner2_x, corner2_y,
		corner3_x, corner3_y, corner4_x, corner4_y, input ready);
	modport sink (input valid, corner1_x, corner1_y, corner2_x, corner2_y,
		corner3_x, corner3_y, corner4_x, corner4_y, output ready);
endinterface

>>> rtl/qpws_out_if.sv
// ----------------------------------------------------------------------------
// qpws_out_if
// Output channel: four corner weights and the degenerate flag per beat.
// ----------------------------------------------------------------------------
interface qpws_out_if
	import qpws_pkg::*;
();
	logic    valid;
	logic    ready;
	weight_t weight1;
	weight_t weight2;
	weight_t weight3;
	weight_t weight4;
	logic    degenerate;

	modport source (output valid, weight1, weight2, weight3, weight4, degenerate,
		input ready);
	modport sink (input valid, weight1, weight2, weight3, weight4, degenerate,
		output ready);
endinterface

>>> rtl/quad_projective_weight_setup_unit.sv
// Pipeline: 6 setup stages plus one stage per weight bit of the restoring
// divider, 24 bits, from input beat to output beat.
// Throughput: one quad per cycle while the output takes beats; every stage holds one beat and advances when
// the stage after it is empty or advancing, so bubbles collapse under stall.
// Reset: arst_n clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quad_projective_weight_setup_unit
// Diagonal intersection of a quad by exact cross products, then four
// pipelined dividers give q = (own + opposite) / opposite distance in Q8.16.
// ----------------------------------------------------------------------------
module quad_projective_weight_setup_unit
	import qpws_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	qpws_in_if.sink    quad_in,
	qpws_out_if.source quad_out
);

	function automatic logic [MAG_W-1:0] mag(input logic signed [DEN_W-1:0] v);
		logic signed [DEN_W-1:0] n;
		n = -v;
		return v[DEN_W-1] ? $unsigned(n) : $unsigned(v);
	endfunction

	// stage valids and advance enables
	logic [NUM_ST-1:0] vld_q;
	logic [NUM_ST-1:0] en;

	assign en[NUM_ST-1] = !vld_q[NUM_ST-1] || quad_out.ready;
	for (genvar k = 0; k < NUM_ST - 1; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	assign quad_in.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= quad_in.valid;
			end
			for (int k = 1; k < NUM_ST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// s1: diagonal and edge vectors
	logic signed [DIFF_W-1:0] ax_s1, ay_s1, bx_s1, by_s1, ex_s1, ey_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ax_s1 <= DIFF_W'(quad_in.corner4_x) - DIFF_W'(quad_in.corner1_x);
			ay_s1 <= DIFF_W'(quad_in.corner4_y) - DIFF_W'(quad_in.corner1_y);
			bx_s1 <= DIFF_W'(quad_in.corner3_x) - DIFF_W'(quad_in.corner2_x);
			by_s1 <= DIFF_W'(quad_in.corner3_y) - DIFF_W'(quad_in.corner2_y);
			ex_s1 <= DIFF_W'(quad_in.corner2_x) - DIFF_W'(quad_in.corner1_x);
			ey_s1 <= DIFF_W'(quad_in.corner2_y) - DIFF_W'(quad_in.corner1_y);
		end
	end

	// s2: the six products of the three cross products
	logic signed [PROD_W-1:0] p_s2 [6];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s2[0] <= ax_s1 * by_s1;
			p_s2[1] <= ay_s1 * bx_s1;
			p_s2[2] <= ex_s1 * by_s1;
			p_s2[3] <= ey_s1 * bx_s1;
			p_s2[4] <= ex_s1 * ay_s1;
			p_s2[5] <= ey_s1 * ax_s1;
		end
	end

	// s3: den, tn, sn
	logic signed [CROSS_W-1:0] den_s3, tn_s3, sn_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			den_s3 <= CROSS_W'(p_s2[0]) - CROSS_W'(p_s2[1]);
			tn_s3  <= CROSS_W'(p_s2[2]) - CROSS_W'(p_s2[3]);
			sn_s3  <= CROSS_W'(p_s2[4]) - CROSS_W'(p_s2[5]);
		end
	end

	// s4: opposite numerators, degenerate test, near distances
	logic signed [DEN_W-1:0] dmt_s4, dms_s4;
	logic [MAG_W-1:0]        d1_s4, d2_s4;
	logic                    degen_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dmt_s4   <= DEN_W'(den_s3) - DEN_W'(tn_s3);
			dms_s4   <= DEN_W'(den_s3) - DEN_W'(sn_s3);
			d1_s4    <= mag(DEN_W'(tn_s3));
			d2_s4    <= mag(DEN_W'(sn_s3));
			degen_s4 <= (den_s3 == '0) || (tn_s3 == '0) || (sn_s3 == '0) ||
				(tn_s3 == den_s3) || (sn_s3 == den_s3);
		end
	end

	// s5: far distances and diagonal sums
	logic [MAG_W-1:0] d1_s5, d2_s5, d3_s5, d4_s5;
	logic [SUM_W-1:0] s14_s5, s23_s5;
	logic             degen_s5;
	logic [MAG_W-1:0] d3_c, d4_c;

	assign d4_c = mag(dmt_s4);
	assign d3_c = mag(dms_s4);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			d1_s5    <= d1_s4;
			d2_s5    <= d2_s4;
			d3_s5    <= d3_c;
			d4_s5    <= d4_c;
			s14_s5   <= SUM_W'(d1_s4) + SUM_W'(d4_c);
			s23_s5   <= SUM_W'(d2_s4) + SUM_W'(d3_c);
			degen_s5 <= degen_s4;
		end
	end

	// s6 onward: divider stages, div_s[0] is the loaded numerator
	div_stage_t div_s [WEIGHT_WIDTH+1];
	logic [SUM_W-1:0] num_c [LANES];
	logic [MAG_W-1:0] dvs_c [LANES];

	assign num_c[0] = s14_s5;
	assign dvs_c[0] = d4_s5;
	assign num_c[1] = s23_s5;
	assign dvs_c[1] = d3_s5;
	assign num_c[2] = s23_s5;
	assign dvs_c[2] = d2_s5;
	assign num_c[3] = s14_s5;
	assign dvs_c[3] = d1_s5;

	// quotient overflows when num >= dvs << (WEIGHT_WIDTH - FRAC_BITS)
	always_ff @(posedge clk) begin
		if (en[FRONT_ST-1]) begin
			div_s[0].degen <= degen_s5;
			for (int l = 0; l < LANES; l++) begin
				div_s[0].lane[l].rem <= REM_W'(num_c[l]) << FRAC_BITS;
				div_s[0].lane[l].dvs <= dvs_c[l];
				div_s[0].lane[l].quo <= '0;
				div_s[0].lane[l].sat <= degen_s5 || (REM_W'(num_c[l]) >=
					(REM_W'(dvs_c[l]) << (WEIGHT_WIDTH - FRAC_BITS)));
			end
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar k = 1; k <= WEIGHT_WIDTH; k++) begin : g_div
		localparam int BIT = WEIGHT_WIDTH - k;
		logic [REM_W-1:0] trial [LANES];
		div_stage_t       nxt;

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			assign trial[l] = REM_W'(div_s[k-1].lane[l].dvs) << BIT;
		end

		always_comb begin
			nxt = div_s[k-1];
			for (int l = 0; l < LANES; l++) begin
				if (div_s[k-1].lane[l].rem >= trial[l]) begin
					nxt.lane[l].rem      = div_s[k-1].lane[l].rem - trial[l];
					nxt.lane[l].quo[BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[FRONT_ST-1+k]) begin
				div_s[k] <= nxt;
			end
		end
	end

	// output beat
	assign quad_out.valid      = vld_q[NUM_ST-1];
	assign quad_out.degenerate = div_s[WEIGHT_WIDTH].degen;
	assign quad_out.weight1 = div_s[WEIGHT_WIDTH].lane[0].sat ? WEIGHT_MAX :
		div_s[WEIGHT_WIDTH].lane[0].quo;
	assign quad_out.weight2 = div_s[WEIGHT_WIDTH].lane[1].sat ? WEIGHT_MAX :
		div_s[WEIGHT_WIDTH].lane[1].quo;
	assign quad_out.weight3 = div_s[WEIGHT_WIDTH].lane[2].sat ? WEIGHT_MAX :
		div_s[WEIGHT_WIDTH].lane[2].quo;
	assign quad_out.weight4 = div_s[WEIGHT_WIDTH].lane[3].sat ? WEIGHT_MAX :
		div_s[WEIGHT_WIDTH].lane[3].quo;

endmodule

>>> rtl/qpws_checker.sv
// ----------------------------------------------------------------------------
// qpws_checker
// Port-level checks for the quad projective weight setup unit.
// ----------------------------------------------------------------------------
`include "quad_projective_weight_setup_unit_defines.svh"

module qpws_checker
	import qpws_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input weight_t weight1,
	input weight_t weight2,
	input weight_t weight3,
	input weight_t weight4,
	input logic    degenerate
);

	localparam weight_t ONE_Q = weight_t'(1) << FRAC_BITS;

	// a stalled output beat stays up
	`QPWS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// degenerate beats carry saturated weights
	`QPWS_ASSERT_NOW(a_degen_sat, clk, arst_n, out_valid && degenerate, (weight1 == WEIGHT_MAX) && (weight2 == WEIGHT_MAX) && (weight3 == WEIGHT_MAX) && (weight4 == WEIGHT_MAX))

	// every weight is at least one, since own plus opposite >= opposite
	`QPWS_ASSERT_NOW(a_weight_min, clk, arst_n, out_valid, (weight1 >= ONE_Q) && (weight2 >= ONE_Q) && (weight3 >= ONE_Q) && (weight4 >= ONE_Q))

	// an empty output stage lets the whole pipe advance
	`QPWS_ASSERT_NOW(a_ready_free, clk, arst_n, !out_valid, in_ready)

endmodule

bind quad_projective_weight_setup_unit qpws_checker u_qpws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (quad_in.ready),
	.out_valid  (quad_out.valid),
	.out_ready  (quad_out.ready),
	.weight1    (quad_out.weight1),
	.weight2    (quad_out.weight2),
	.weight3    (quad_out.weight3),
	.weight4    (quad_out.weight4),
	.degenerate (quad_out.degenerate)
);
